@@ rtl/core/aat_pkg.sv @@
`timescale 1ns / 1ps

package aat_pkg;

  // Table geometry and limits
  localparam int ENTRIES_DEF    = 16;
  localparam int QDEPTH         = 2;
  localparam logic [31:0] TIMEOUT_RESET = 32'd30000;
  localparam logic [4:0]  MAX_RESULTS   = 5'd16;

  // Operation codes
  localparam logic OP_TOUCH = 1'b0;
  localparam logic OP_LIST  = 1'b1;

  // Command as it sits in the queue
  typedef struct packed {
    logic        op;
    logic [31:0] now;
    logic [31:0] addr;
    logic [4:0]  limit;
  } cmd_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_WRITE,
    B_DONE
  } back_state_t;

endpackage

@@ rtl/core/aat_ram.sv @@
`timescale 1ns / 1ps

module aat_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one word, read one word with a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/aat_front.sv @@
`timescale 1ns / 1ps

module aat_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              operation,
  input  logic [31:0]       now_ms,
  input  logic [31:0]       address,
  input  logic [4:0]        max_count,
  output logic              busy,
  output logic              q_valid,
  output aat_pkg::cmd_t     q_cmd,
  input  logic              q_pop
);

  localparam int QD     = aat_pkg::QDEPTH;
  localparam int PTR_W  = (QD > 1) ? $clog2(QD) : 1;
  localparam int CNT_W  = $clog2(QD + 1);

  aat_pkg::cmd_t      q_r [QD];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  aat_pkg::cmd_t      cmd_in;
  logic               push;

  // Classify the incoming transfer and clamp the count limit
  always_comb begin
    cmd_in.op    = operation;
    cmd_in.now   = now_ms;
    cmd_in.addr  = address;
    cmd_in.limit = (max_count > aat_pkg::MAX_RESULTS) ? aat_pkg::MAX_RESULTS : max_count;
  end

  assign busy    = (cnt_r == CNT_W'(QD));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = q_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QD - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QD - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

@@ rtl/core/aat_back.sv @@
`timescale 1ns / 1ps

module aat_back #(
  parameter int ENTRIES = aat_pkg::ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [31:0]       timeout_ms,
  input  logic              q_valid,
  input  aat_pkg::cmd_t     q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  output logic [31:0]       out_entry_address,
  output logic              out_entry_valid,
  output logic [3:0]        out_slot,
  output logic              out_hit,
  output logic              out_last
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  aat_pkg::back_state_t state_r, state_nxt;
  aat_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [IDX_W-1:0]     p_r, p_nxt;
  logic [4:0]           count_r, count_nxt;
  logic                 match_r, match_nxt;
  logic [IDX_W-1:0]     match_slot_r, match_slot_nxt;
  logic                 free_r, free_nxt;
  logic [IDX_W-1:0]     free_slot_r, free_slot_nxt;
  logic [31:0]          old_time_r, old_time_nxt;
  logic [IDX_W-1:0]     old_slot_r, old_slot_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic [31:0]          pend_addr_r, pend_addr_nxt;
  logic [IDX_W-1:0]     pend_slot_r, pend_slot_nxt;
  logic [ENTRIES-1:0]   valid_r, valid_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [31:0]          out_addr_r, out_addr_nxt;
  logic                 out_ev_r, out_ev_nxt;
  logic [3:0]           out_slot_r, out_slot_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [IDX_W-1:0]     ram_raddr;
  logic [63:0]          ram_wdata;
  logic [63:0]          ram_rdata;

  logic [31:0]          ent_addr;
  logic [31:0]          ent_time;
  logic                 cur_v;
  logic                 is_last_p;
  logic                 lim_hit;
  logic                 expired;
  logic [IDX_W-1:0]     p_inc;
  logic [IDX_W-1:0]     emit_idx;
  logic [IDX_W+3:0]     emit_idx_ext;
  logic [IDX_W-1:0]     wr_slot;

  // Address and timestamp of each slot, one word per slot
  aat_ram #(
    .WIDTH (64),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ent_addr  = ram_rdata[63:32];
  assign ent_time  = ram_rdata[31:0];
  assign cur_v     = valid_r[p_r];
  assign is_last_p = (p_r == LAST_IDX);
  assign lim_hit   = (count_r == cmd_r.limit);
  assign expired   = ((cmd_r.now - ent_time) > timeout_ms);
  assign p_inc     = is_last_p ? p_r : p_r + 1'b1;
  assign wr_slot   = match_r ? match_slot_r : (free_r ? free_slot_r : old_slot_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aat_pkg::B_IDLE: begin
        if (q_valid) begin
          state_nxt = aat_pkg::B_SCAN;
        end
      end
      aat_pkg::B_SCAN: begin
        if (cmd_r.op == aat_pkg::OP_TOUCH) begin
          if (is_last_p) begin
            state_nxt = aat_pkg::B_WRITE;
          end
        end else if (lim_hit || is_last_p) begin
          state_nxt = aat_pkg::B_DONE;
        end
      end
      aat_pkg::B_WRITE: state_nxt = aat_pkg::B_IDLE;
      aat_pkg::B_DONE:  state_nxt = aat_pkg::B_IDLE;
      default:          state_nxt = aat_pkg::B_IDLE;
    endcase
  end

  // Datapath and results
  always_comb begin
    cmd_nxt        = cmd_r;
    p_nxt          = p_r;
    count_nxt      = count_r;
    match_nxt      = match_r;
    match_slot_nxt = match_slot_r;
    free_nxt       = free_r;
    free_slot_nxt  = free_slot_r;
    old_time_nxt   = old_time_r;
    old_slot_nxt   = old_slot_r;
    pend_valid_nxt = pend_valid_r;
    pend_addr_nxt  = pend_addr_r;
    pend_slot_nxt  = pend_slot_r;
    valid_nxt      = valid_r;
    q_pop          = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = wr_slot;
    ram_wdata      = {cmd_r.addr, cmd_r.now};
    ram_raddr      = p_r;
    out_valid_nxt  = 1'b0;
    out_addr_nxt   = out_addr_r;
    out_ev_nxt     = out_ev_r;
    emit_idx       = '0;
    out_hit_nxt    = out_hit_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      aat_pkg::B_IDLE: begin
        // Take the next command and start the read of slot zero
        if (q_valid) begin
          q_pop          = 1'b1;
          cmd_nxt        = q_cmd;
          p_nxt          = '0;
          ram_raddr      = '0;
          count_nxt      = '0;
          match_nxt      = 1'b0;
          free_nxt       = 1'b0;
          old_time_nxt   = q_cmd.now;
          old_slot_nxt   = '0;
          pend_valid_nxt = 1'b0;
        end
      end
      aat_pkg::B_SCAN: begin
        ram_raddr = p_inc;
        p_nxt     = p_inc;
        if (cmd_r.op == aat_pkg::OP_TOUCH) begin
          // Look for a match, the first free slot and the oldest slot before it
          if (cur_v && (ent_addr == cmd_r.addr) && !match_r) begin
            match_nxt      = 1'b1;
            match_slot_nxt = p_r;
          end
          if (!cur_v && !free_r) begin
            free_nxt      = 1'b1;
            free_slot_nxt = p_r;
          end
          if (cur_v && !free_r && (ent_time < old_time_r)) begin
            old_time_nxt = ent_time;
            old_slot_nxt = p_r;
          end
        end else if (!lim_hit && cur_v) begin
          if (expired) begin
            // Drop the aged entry
            valid_nxt[p_r] = 1'b0;
          end else begin
            // Release the held result, hold the new one
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_addr_nxt  = pend_addr_r;
              out_ev_nxt    = 1'b1;
              emit_idx      = pend_slot_r;
              out_hit_nxt   = 1'b0;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_addr_nxt  = ent_addr;
            pend_slot_nxt  = p_r;
            count_nxt      = count_r + 1'b1;
          end
        end
      end
      aat_pkg::B_WRITE: begin
        // Store address and time, report the slot
        ram_we             = 1'b1;
        valid_nxt[wr_slot] = 1'b1;
        out_valid_nxt      = 1'b1;
        out_addr_nxt       = cmd_r.addr;
        out_ev_nxt         = 1'b1;
        emit_idx           = wr_slot;
        out_hit_nxt        = match_r;
        out_last_nxt       = 1'b1;
      end
      aat_pkg::B_DONE: begin
        // Close the list with the held result or an empty one
        out_valid_nxt  = 1'b1;
        out_addr_nxt   = pend_valid_r ? pend_addr_r : '0;
        out_ev_nxt     = pend_valid_r;
        emit_idx       = pend_valid_r ? pend_slot_r : '0;
        out_hit_nxt    = 1'b0;
        out_last_nxt   = 1'b1;
        pend_valid_nxt = 1'b0;
      end
      default: begin
        pend_valid_nxt = 1'b0;
      end
    endcase
  end

  assign emit_idx_ext = {4'b0000, emit_idx};
  assign out_slot_nxt = emit_idx_ext[3:0];

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= aat_pkg::B_IDLE;
      valid_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    p_r          <= p_nxt;
    count_r      <= count_nxt;
    match_r      <= match_nxt;
    match_slot_r <= match_slot_nxt;
    free_r       <= free_nxt;
    free_slot_r  <= free_slot_nxt;
    old_time_r   <= old_time_nxt;
    old_slot_r   <= old_slot_nxt;
    pend_addr_r  <= pend_addr_nxt;
    pend_slot_r  <= pend_slot_nxt;
    out_addr_r   <= out_addr_nxt;
    out_ev_r     <= out_ev_nxt;
    out_slot_r   <= out_slot_nxt;
    out_hit_r    <= out_hit_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_entry_address = out_addr_r;
  assign out_entry_valid   = out_ev_r;
  assign out_slot          = out_slot_r;
  assign out_hit           = out_hit_r;
  assign out_last          = out_last_r;

  // A touch always ends in one final result
  a_write_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aat_pkg::B_WRITE) |=> (out_valid_r && out_last_r && out_ev_r))
    else $error("touch write without final result");

  // A list never returns more than its limit
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aat_pkg::B_SCAN) |-> (count_r <= cmd_r.limit))
    else $error("list count past limit");

  // No held result survives the end of an item
  a_pend_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == aat_pkg::B_IDLE) |-> !pend_valid_r)
    else $error("held result left over");

  // An empty result only closes an item
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ev_r) |-> (out_last_r && !out_hit_r))
    else $error("empty result not final");

endmodule

@@ rtl/core/active_address_table_with_aging_unit.sv @@
`timescale 1ns / 1ps

// Table of recently seen addresses with timestamps. A command is taken when
// start is high and busy is low; two commands can wait in the input queue
// while one is carried out. Each command walks the table one slot per clock
// through the single read port of the slot memory. A touch takes the command
// from the queue, reads every slot in turn and then writes; a list takes the
// command and reads slots until its limit or the last slot, then closes. A
// queued command is taken in the cycle after the write or close. A touch
// result is registered in the write state. A listed entry is held until
// the walk meets another listed entry or closes, and shows in the cycle
// after that. Every result is on the out_ ports for exactly one cycle with
// out_valid high and cannot be held off, so the receiver must take it then.
// out_last marks the final result of a command. timeout_ms is written
// through cfg_we/cfg_data and should only change while the block is idle.
module active_address_table_with_aging_unit #(
  parameter int ENTRIES = aat_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [31:0] in_now_ms,
  input  logic [31:0] in_address,
  input  logic [4:0]  in_max_count,
  output logic        out_valid,
  output logic [31:0] out_entry_address,
  output logic        out_entry_valid,
  output logic [3:0]  out_slot,
  output logic        out_hit,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data
);

  logic [31:0]    timeout_r;
  logic           q_valid;
  logic           q_pop;
  aat_pkg::cmd_t  q_cmd;

  // Hold the timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= aat_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_data;
    end
  end

  aat_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_operation),
    .now_ms    (in_now_ms),
    .address   (in_address),
    .max_count (in_max_count),
    .busy      (busy),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  aat_back #(
    .ENTRIES (ENTRIES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .timeout_ms        (timeout_r),
    .q_valid           (q_valid),
    .q_cmd             (q_cmd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_entry_address (out_entry_address),
    .out_entry_valid   (out_entry_valid),
    .out_slot          (out_slot),
    .out_hit           (out_hit),
    .out_last          (out_last)
  );

endmodule
